// ===== rtl/hftc_pkg.sv =====
// Shared types and constants for the Huffman table codec.
package hftc_pkg;

  localparam int SYM_W    = 8;
  localparam int FREQ_W   = 24;
  localparam int WEIGHT_W = 31;
  localparam int CODE_W   = 63;
  localparam int LEN_W    = 6;
  localparam int STAT_W   = 2;
  localparam int SYM_CNT  = 256;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_DECODE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_UNKNOWN   = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_BUILT = 2'd2;
  localparam logic [STAT_W-1:0] ST_TOO_MANY  = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE, S_ENC1, S_ENC2, S_DEC1, S_DEC2, S_BUILD, S_SCAN_INIT, S_SCAN,
    S_MERGE_NODE, S_MERGE_PA, S_MERGE_PB, S_WALK_INIT, S_WALK_LEAF, S_WALK_P,
    S_WALK_UP, S_FINISH, S_EMIT
  } state_t;

  typedef enum logic [4:0] {
    DP_NOP, DP_ACCEPT, DP_ENC_LOOK, DP_ENC_DONE, DP_DEC_STEP, DP_DEC_DONE,
    DP_BUILD_INIT, DP_SCAN_INIT, DP_SCAN, DP_MERGE_NODE, DP_MERGE_PA, DP_MERGE_PB,
    DP_WALK_INIT, DP_WALK_LEAF, DP_WALK_P, DP_WALK_UP, DP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   emit;
  } cmd_t;

  typedef struct packed {
    logic ready;
    logic will_drop;
    logic drop;
    logic enc_present;
    logic dec_hit;
    logic scan_done;
    logic merges_done;
    logic p_zero;
    logic walk_last;
    logic n_zero;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/hftc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module hftc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/hftc_datapath.sv =====
// Node tables, code tables, search and walk registers, result and output registers.
module hftc_datapath
  import hftc_pkg::*;
#(
  parameter int MAX_LEAVES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic [1:0]          in_opcode,
  input  logic [SYM_W-1:0]    in_symbol,
  input  logic [FREQ_W-1:0]   in_frequency,
  input  logic                in_bit_in,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SYM_W-1:0]    out_symbol,
  output logic [CODE_W-1:0]   out_code_bits,
  output logic [LEN_W-1:0]    out_code_length,
  output logic [STAT_W-1:0]   out_status
);

  localparam int NODE_CAP = 2 * MAX_LEAVES - 1;
  localparam int NODE_W   = $clog2(NODE_CAP);
  localparam int LEAF_W   = $clog2(MAX_LEAVES);
  localparam int CNT_W    = $clog2(MAX_LEAVES + 1);

  // table state
  logic [CNT_W-1:0]   count_r;
  logic               ready_r;
  logic [NODE_W-1:0]  cursor_r;
  logic [SYM_CNT-1:0] sym_valid_r;

  // staged result
  logic [SYM_W-1:0]   res_sym_r;
  logic [CODE_W-1:0]  res_word_r;
  logic [LEN_W-1:0]   res_len_r;
  logic [STAT_W-1:0]  res_status_r;
  logic               drop_r;
  logic               present_r;
  logic               bit_r;
  logic [NODE_W-1:0]  tgt_r;

  // merge search
  logic [NODE_W-1:0]   t_r;
  logic [NODE_W-1:0]   scan_i_r;
  logic                cmp_v_r;
  logic [NODE_W-1:0]   cmp_idx_r;
  logic [NODE_W-1:0]   a_r;
  logic [NODE_W-1:0]   b_r;
  logic                a_v_r;
  logic                b_v_r;
  logic [WEIGHT_W-1:0] wa_r;
  logic [WEIGHT_W-1:0] wb_r;

  // code walk
  logic [LEAF_W-1:0]  leaf_i_r;
  logic [NODE_W-1:0]  cur_r;
  logic [NODE_W-1:0]  p_r;
  logic [CODE_W-1:0]  word_r;
  logic [LEN_W-1:0]   len_r;

  // output register
  logic               out_valid_r;
  logic [SYM_W-1:0]   out_sym_r;
  logic [CODE_W-1:0]  out_word_r;
  logic [LEN_W-1:0]   out_len_r;
  logic [STAT_W-1:0]  out_status_r;

  // memory ports
  logic                w_we, p_we, l_we, r_we, ls_we, cw_we, s2l_we;
  logic [NODE_W-1:0]   w_waddr, p_waddr, n_raddr, r_raddr;
  logic [WEIGHT_W-1:0] w_wdata, w_rdata;
  logic [NODE_W-1:0]   p_wdata, p_raddr, p_rdata, l_rdata, r_rdata;
  logic [SYM_W-1:0]    ls_rdata;
  logic [LEAF_W-1:0]   cw_addr_w, cw_raddr, s2l_wdata, s2l_rdata;
  logic [CODE_W-1:0]   cw_rdata;
  logic [LEN_W-1:0]    len_rdata;
  logic [NODE_W-1:0]   ls_raddr;

  logic [CNT_W-1:0]    eff_cnt;
  logic                will_drop;
  logic [NODE_W-1:0]   n_node;
  logic [NODE_W-1:0]   root;
  logic [NODE_W-1:0]   last_node;
  logic [NODE_W-1:0]   target;
  logic [WEIGHT_W:0]   wsum;
  logic                is_load;
  logic                scan_issue;
  logic                out_free;

  assign eff_cnt    = ready_r ? '0 : count_r;
  assign will_drop  = (eff_cnt == CNT_W'(MAX_LEAVES));
  assign n_node     = NODE_W'(count_r);
  assign root       = NODE_W'({n_node, 1'b0} - 2);
  assign last_node  = NODE_W'({n_node, 1'b0} - 1);
  assign target     = (cursor_r < n_node) ? cursor_r : (bit_r ? r_rdata : l_rdata);
  assign wsum       = {1'b0, wa_r} + {1'b0, wb_r};
  assign is_load    = (cmd.op == DP_ACCEPT) && (in_opcode == OP_LOAD) && !will_drop;
  assign scan_issue = (scan_i_r < t_r);
  assign out_free   = !out_valid_r || !out_stall;

  always_comb begin
    w_we      = 1'b0;
    p_we      = 1'b0;
    l_we      = 1'b0;
    r_we      = 1'b0;
    ls_we     = 1'b0;
    cw_we     = 1'b0;
    s2l_we    = is_load;
    w_waddr   = t_r;
    w_wdata   = wsum[WEIGHT_W-1:0];
    p_waddr   = t_r;
    p_wdata   = '0;
    n_raddr   = scan_i_r;
    p_raddr   = scan_i_r;
    r_raddr   = cursor_r;
    ls_raddr  = target;
    cw_raddr  = s2l_rdata;
    cw_addr_w = leaf_i_r;
    s2l_wdata = LEAF_W'(eff_cnt);
    case (cmd.op)
      DP_ACCEPT: begin
        if (is_load) begin
          w_we    = 1'b1;
          p_we    = 1'b1;
          ls_we   = 1'b1;
          w_waddr = NODE_W'(eff_cnt);
          w_wdata = WEIGHT_W'(in_frequency);
          p_waddr = NODE_W'(eff_cnt);
        end
      end
      DP_MERGE_NODE: begin
        w_we = 1'b1;
        p_we = 1'b1;
        l_we = 1'b1;
        r_we = 1'b1;
      end
      DP_MERGE_PA: begin
        p_we    = 1'b1;
        p_waddr = a_r;
        p_wdata = t_r;
      end
      DP_MERGE_PB: begin
        p_we    = 1'b1;
        p_waddr = b_r;
        p_wdata = t_r;
      end
      DP_WALK_LEAF: p_raddr = NODE_W'(leaf_i_r);
      DP_WALK_P: begin
        r_raddr = p_rdata;
        cw_we   = (p_rdata == '0);
      end
      DP_WALK_UP: p_raddr = p_r;
      default: ;
    endcase
  end

  hftc_ram #(.WIDTH(WEIGHT_W), .DEPTH(NODE_CAP)) u_weight (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata), .raddr(n_raddr), .rdata(w_rdata)
  );
  hftc_ram #(.WIDTH(NODE_W), .DEPTH(NODE_CAP)) u_parent (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata), .raddr(p_raddr), .rdata(p_rdata)
  );
  hftc_ram #(.WIDTH(NODE_W), .DEPTH(NODE_CAP)) u_left (
    .clk(clk), .we(l_we), .waddr(t_r), .wdata(a_r), .raddr(cursor_r), .rdata(l_rdata)
  );
  hftc_ram #(.WIDTH(NODE_W), .DEPTH(NODE_CAP)) u_right (
    .clk(clk), .we(r_we), .waddr(t_r), .wdata(b_r), .raddr(r_raddr), .rdata(r_rdata)
  );
  hftc_ram #(.WIDTH(SYM_W), .DEPTH(NODE_CAP)) u_leaf_sym (
    .clk(clk), .we(ls_we), .waddr(NODE_W'(eff_cnt)), .wdata(in_symbol),
    .raddr(ls_raddr), .rdata(ls_rdata)
  );
  hftc_ram #(.WIDTH(CODE_W), .DEPTH(MAX_LEAVES)) u_code_word (
    .clk(clk), .we(cw_we), .waddr(cw_addr_w), .wdata(word_r), .raddr(cw_raddr),
    .rdata(cw_rdata)
  );
  hftc_ram #(.WIDTH(LEN_W), .DEPTH(MAX_LEAVES)) u_code_len (
    .clk(clk), .we(cw_we), .waddr(cw_addr_w), .wdata(len_r), .raddr(cw_raddr),
    .rdata(len_rdata)
  );
  hftc_ram #(.WIDTH(LEAF_W), .DEPTH(SYM_CNT)) u_sym_to_leaf (
    .clk(clk), .we(s2l_we), .waddr(in_symbol), .wdata(s2l_wdata), .raddr(in_symbol),
    .rdata(s2l_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ready_r     <= 1'b0;
      cursor_r    <= '0;
      sym_valid_r <= '0;
      drop_r      <= 1'b0;
      cmp_v_r     <= 1'b0;
      a_v_r       <= 1'b0;
      b_v_r       <= 1'b0;
      t_r         <= '0;
      scan_i_r    <= '0;
      leaf_i_r    <= '0;
    end else begin
      case (cmd.op)
        DP_ACCEPT: begin
          res_sym_r  <= (in_opcode == OP_DECODE) ? '0 : in_symbol;
          res_word_r <= '0;
          res_len_r  <= '0;
          if (in_opcode == OP_LOAD) begin
            res_status_r <= ST_TOO_MANY;
          end else begin
            res_status_r <= ready_r ? ST_OK : ST_NOT_BUILT;
          end
          bit_r     <= in_bit_in;
          present_r <= sym_valid_r[in_symbol];
          if (in_opcode == OP_LOAD) begin
            // a load after a build starts a fresh table
            if (ready_r) begin
              ready_r  <= 1'b0;
              cursor_r <= '0;
            end
            drop_r      <= will_drop;
            count_r     <= will_drop ? eff_cnt : CNT_W'(eff_cnt + 1'b1);
            sym_valid_r <= (ready_r ? '0 : sym_valid_r) |
                           (will_drop ? '0 : (SYM_CNT'(1) << in_symbol));
          end
        end
        DP_ENC_LOOK: begin
          if (!present_r) begin
            res_status_r <= ST_UNKNOWN;
          end
        end
        DP_ENC_DONE: begin
          res_word_r <= cw_rdata;
          res_len_r  <= len_rdata;
        end
        DP_DEC_STEP: tgt_r <= target;
        DP_DEC_DONE: begin
          if (tgt_r < n_node) begin
            res_sym_r <= ls_rdata;
            cursor_r  <= root;
          end else begin
            cursor_r <= tgt_r;
          end
        end
        DP_BUILD_INIT: t_r <= n_node;
        DP_SCAN_INIT: begin
          scan_i_r <= '0;
          cmp_v_r  <= 1'b0;
          a_v_r    <= 1'b0;
          b_v_r    <= 1'b0;
        end
        DP_SCAN: begin
          if (scan_issue) begin
            scan_i_r <= NODE_W'(scan_i_r + 1'b1);
          end
          cmp_v_r   <= scan_issue;
          cmp_idx_r <= scan_i_r;
          // keep the two lightest parentless nodes, earliest wins on ties
          if (cmp_v_r && (p_rdata == '0)) begin
            if (!a_v_r || (w_rdata < wa_r)) begin
              b_r   <= a_r;
              wb_r  <= wa_r;
              b_v_r <= a_v_r;
              a_r   <= cmp_idx_r;
              wa_r  <= w_rdata;
              a_v_r <= 1'b1;
            end else if (!b_v_r || (w_rdata < wb_r)) begin
              b_r   <= cmp_idx_r;
              wb_r  <= w_rdata;
              b_v_r <= 1'b1;
            end
          end
        end
        DP_MERGE_PB: t_r <= NODE_W'(t_r + 1'b1);
        DP_WALK_INIT: leaf_i_r <= '0;
        DP_WALK_LEAF: begin
          cur_r  <= NODE_W'(leaf_i_r);
          word_r <= '0;
          len_r  <= '0;
        end
        DP_WALK_P: begin
          if (p_rdata != '0) begin
            p_r <= p_rdata;
          end else begin
            leaf_i_r <= LEAF_W'(leaf_i_r + 1'b1);
          end
        end
        DP_WALK_UP: begin
          if (r_rdata == cur_r) begin
            word_r <= word_r | (CODE_W'(1) << len_r);
          end
          len_r <= LEN_W'(len_r + 1'b1);
          cur_r <= p_r;
        end
        DP_FINISH: begin
          cursor_r <= root;
          ready_r  <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r  <= 1'b1;
      out_sym_r    <= res_sym_r;
      out_word_r   <= res_word_r;
      out_len_r    <= res_len_r;
      out_status_r <= res_status_r;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_symbol      = out_sym_r;
  assign out_code_bits   = out_word_r;
  assign out_code_length = out_len_r;
  assign out_status      = out_status_r;

  always_comb begin
    sts.ready       = ready_r;
    sts.will_drop   = will_drop;
    sts.drop        = drop_r;
    sts.enc_present = present_r;
    sts.dec_hit     = (tgt_r < n_node);
    sts.scan_done   = (scan_i_r == t_r) && !cmp_v_r;
    sts.merges_done = (t_r == last_node);
    sts.p_zero      = (p_rdata == '0);
    sts.walk_last   = (leaf_i_r == LEAF_W'(count_r - 1'b1));
    sts.n_zero      = (count_r == '0);
    sts.out_free    = out_free;
  end

  a_merge_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == DP_MERGE_NODE) |-> (a_v_r && b_v_r && (a_r != b_r)))
    else $error("merge without two distinct parentless nodes");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || !out_stall))
    else $error("result overwrites a pending transfer");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r |-> (cursor_r <= root))
    else $error("decode cursor beyond root");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == DP_WALK_UP) |-> (len_r < LEN_W'(MAX_LEAVES - 1)))
    else $error("code walk deeper than the tree allows");

endmodule

// ===== rtl/hftc_ctrl.sv =====
// Sequencer for load, encode, decode, table build and result transfer.
module hftc_ctrl
  import hftc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_opcode,
  input  logic       in_last,
  output logic       in_stall,
  input  sts_t       sts,
  output cmd_t       cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = DP_NOP;
    cmd.emit  = 1'b0;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op = DP_ACCEPT;
          case (in_opcode)
            OP_LOAD: begin
              if (in_last) begin
                state_nxt = S_BUILD;
              end else if (sts.will_drop) begin
                state_nxt = S_EMIT;
              end
            end
            OP_ENCODE: state_nxt = sts.ready ? S_ENC1 : S_EMIT;
            OP_DECODE: state_nxt = sts.ready ? S_DEC1 : S_EMIT;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_ENC1: begin
        cmd.op    = DP_ENC_LOOK;
        state_nxt = sts.enc_present ? S_ENC2 : S_EMIT;
      end
      S_ENC2: begin
        cmd.op    = DP_ENC_DONE;
        state_nxt = S_EMIT;
      end
      S_DEC1: begin
        cmd.op    = DP_DEC_STEP;
        state_nxt = S_DEC2;
      end
      S_DEC2: begin
        cmd.op    = DP_DEC_DONE;
        state_nxt = sts.dec_hit ? S_EMIT : S_IDLE;
      end
      S_BUILD: begin
        cmd.op    = DP_BUILD_INIT;
        state_nxt = sts.n_zero ? S_IDLE : S_SCAN_INIT;
      end
      S_SCAN_INIT: begin
        if (sts.merges_done) begin
          state_nxt = S_WALK_INIT;
        end else begin
          cmd.op    = DP_SCAN_INIT;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.op = DP_SCAN;
        if (sts.scan_done) begin
          state_nxt = S_MERGE_NODE;
        end
      end
      S_MERGE_NODE: begin
        cmd.op    = DP_MERGE_NODE;
        state_nxt = S_MERGE_PA;
      end
      S_MERGE_PA: begin
        cmd.op    = DP_MERGE_PA;
        state_nxt = S_MERGE_PB;
      end
      S_MERGE_PB: begin
        cmd.op    = DP_MERGE_PB;
        state_nxt = S_SCAN_INIT;
      end
      S_WALK_INIT: begin
        cmd.op    = DP_WALK_INIT;
        state_nxt = S_WALK_LEAF;
      end
      S_WALK_LEAF: begin
        cmd.op    = DP_WALK_LEAF;
        state_nxt = S_WALK_P;
      end
      S_WALK_P: begin
        cmd.op = DP_WALK_P;
        if (!sts.p_zero) begin
          state_nxt = S_WALK_UP;
        end else if (sts.walk_last) begin
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_WALK_LEAF;
        end
      end
      S_WALK_UP: begin
        cmd.op    = DP_WALK_UP;
        state_nxt = S_WALK_P;
      end
      S_FINISH: begin
        cmd.op    = DP_FINISH;
        state_nxt = sts.drop ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        // hold the result until the output register can take it
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE) || (cmd.op != DP_FINISH))
    else $error("finish issued right after a transfer");

  a_emit_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (state_r == S_IDLE))
    else $error("emit did not return to idle");

  a_build_path: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MERGE_PB) |=> (state_r == S_SCAN_INIT))
    else $error("merge sequence broken");

endmodule

// ===== rtl/huffman_table_codec_top.sv =====
// Huffman table codec: leaf load, table build, symbol encode and bit-serial decode.
// An encode reads the code tables; a decode steps the tree by one bit (a bit that ends
// mid-code gives no result); rejected items also give a result. One item is in
// work at a time, and loads are taken one per cycle while the sequencer stays idle.
// Build after the last load: each merge scans the current nodes, then every leaf is
// walked up to the root. Reset (sync, active low) empties table and output.
module huffman_table_codec_top
  import hftc_pkg::*;
#(
  parameter int MAX_LEAVES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_opcode,
  input  logic [SYM_W-1:0]  in_symbol,
  input  logic [FREQ_W-1:0] in_frequency,
  input  logic              in_bit_in,
  input  logic              in_last,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SYM_W-1:0]  out_symbol,
  output logic [CODE_W-1:0] out_code_bits,
  output logic [LEN_W-1:0]  out_code_length,
  output logic [STAT_W-1:0] out_status
);

  cmd_t cmd;
  sts_t sts;

  hftc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_opcode(in_opcode),
    .in_last(in_last), .in_stall(in_stall), .sts(sts), .cmd(cmd)
  );

  hftc_datapath #(.MAX_LEAVES(MAX_LEAVES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_opcode(in_opcode), .in_symbol(in_symbol), .in_frequency(in_frequency),
    .in_bit_in(in_bit_in), .out_valid(out_valid), .out_stall(out_stall),
    .out_symbol(out_symbol), .out_code_bits(out_code_bits),
    .out_code_length(out_code_length), .out_status(out_status)
  );

endmodule
